[rtl/rwct_pkg.sv]
// shared types, constants and cosine table function for the wall column texturer
`default_nettype none

package rwct_pkg;

    // fixed screen geometry
    localparam int SCREEN_HEIGHT = 480;
    localparam int HALF_HEIGHT   = SCREEN_HEIGHT / 2;

    // defaults for the top level parameters
    localparam int TILE_SIZE_DEF = 64;
    localparam int COS_DEPTH_DEF = 1024;

    // word field widths
    localparam int COL_W   = 12;
    localparam int DIST_W  = 24;
    localparam int ANGLE_W = 12;
    localparam int HIT_W   = 16;
    localparam int ROW_W   = 12;
    localparam int TEXEL_W = 22;
    localparam int COS_W   = 16;
    localparam int H_W     = 16;

    // register widths
    localparam int PROJ_W = 20;
    localparam int TEXW_W = 11;
    localparam int BPT_W  = 3;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] REG_PROJ_DIST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TEX_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TEX_HEIGHT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BPT        = 2'd3;

    localparam logic [PROJ_W-1:0] PROJ_DIST_RST  = 20'd47296;
    localparam logic [TEXW_W-1:0] TEX_WIDTH_RST  = 11'd64;
    localparam logic [TEXW_W-1:0] TEX_HEIGHT_RST = 11'd64;
    localparam logic [BPT_W-1:0]  BPT_RST        = 3'd4;

    // item kinds
    localparam logic KIND_COLUMN = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // serial divider produces a 16 bit quotient, one bit a step
    localparam int DIV_STEPS = 16;

    // taylor coefficients of cos(pi/2 * u) in q30
    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned TAY2    = 64'd1324675879;
    localparam longint unsigned TAY4    = 64'd272375560;
    localparam longint unsigned TAY6    = 64'd22401992;
    localparam longint unsigned TAY8    = 64'd987048;
    localparam longint unsigned TAY10   = 64'd27061;

    typedef struct packed {
        logic                      kind;
        logic [COL_W-1:0]          column_x;
        logic [DIST_W-1:0]         ray_distance;
        logic signed [ANGLE_W-1:0] angle_offset;
        logic                      hit_vertical;
        logic [HIT_W-1:0]          hit_x;
        logic [HIT_W-1:0]          hit_y;
    } item_t;

    typedef struct packed {
        logic [COL_W-1:0]   screen_x;
        logic [ROW_W-1:0]   screen_y;
        logic [TEXEL_W-1:0] texel_offset;
        logic               last_pixel;
    } pixel_t;

    function automatic longint unsigned q30_mul(input longint unsigned a,
                                                input longint unsigned b);
        return (a * b) >> 30;
    endfunction

    // table entry from the q30 phase u, evaluated at elaboration only
    function automatic logic [COS_W-1:0] cos_from_u(input longint unsigned u);
        longint unsigned u2;
        longint unsigned u4;
        longint unsigned u6;
        longint unsigned u8;
        longint unsigned u10;
        longint          r;
        longint unsigned v;
        u2  = q30_mul(u, u);
        u4  = q30_mul(u2, u2);
        u6  = q30_mul(u4, u2);
        u8  = q30_mul(u4, u4);
        u10 = q30_mul(u8, u2);
        r = $signed(Q30_ONE)
            - $signed(q30_mul(TAY2, u2))
            + $signed(q30_mul(TAY4, u4))
            - $signed(q30_mul(TAY6, u6))
            + $signed(q30_mul(TAY8, u8))
            - $signed(q30_mul(TAY10, u10));
        if (r < 0)
        begin
            r = 0;
        end
        v = ($unsigned(r) * 64'd65535 + (64'd1 << 29)) >> 30;
        if (v > 64'd65535)
        begin
            v = 64'd65535;
        end
        return 16'(v);
    endfunction

endpackage

`default_nettype wire

[rtl/raycast_wall_column_texturer.sv]
// raycast wall column texturer: projects one wall stripe and walks its pixels
// column start word: busy through rom read, multiply, saturation check, 16 step
//   division, tile reciprocal multiply, remainder, row clamp; saturation skips division
// tick word: multiply, divider load, 16 step division, two multiplies, output load;
//   no work starts when no pixel remains
// rst_n clears control, column state and registers to their defaults at once
`default_nettype none

module raycast_wall_column_texturer #(
    parameter int TILE_SIZE       = rwct_pkg::TILE_SIZE_DEF,
    parameter int COS_TABLE_DEPTH = rwct_pkg::COS_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [rwct_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rwct_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  rwct_pkg::item_t                  item,
    output logic                             pixel_valid,
    input  logic                             pixel_stall,
    output rwct_pkg::pixel_t                 pixel
);

    import rwct_pkg::*;

    // numerator 2 * tile * projection distance
    localparam int NUM_CONST  = 2 * TILE_SIZE;
    localparam int NUM_W      = PROJ_W + $clog2(NUM_CONST + 1);
    // texture column is below the tile size
    localparam int TCOL_W     = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
    // hit / tile as (hit * ceil(2^shift / tile)) >> shift, exact for 16 bit hits
    localparam int MOD_SHIFT  = H_W + TCOL_W;
    localparam logic [DIST_W-1:0] MOD_RECIP =
        DIST_W'(((64'd1 << MOD_SHIFT) + 64'(TILE_SIZE) - 64'd1) / 64'(TILE_SIZE));
    // cosine rom addressing
    localparam int IDX_W      = $clog2(COS_TABLE_DEPTH);
    localparam int IDX_PROD_W = 10 + $clog2(COS_TABLE_DEPTH + 1);
    localparam int CNT_W      = $clog2(DIV_STEPS);

    // sequencer: column path then tick path
    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_COS    = 12'b0000_0000_0010,  // registered rom read
        S_MUL    = 12'b0000_0000_0100,  // distance times cosine
        S_SAT    = 12'b0000_0000_1000,  // saturation check, divider load
        S_DIVH   = 12'b0000_0001_0000,  // height division
        S_MODMUL = 12'b0000_0010_0000,  // hit times tile reciprocal
        S_MODSUB = 12'b0000_0100_0000,  // remainder from the quotient
        S_FIN    = 12'b0000_1000_0000,  // clamp top and bottom rows
        S_TMUL   = 12'b0001_0000_0000,  // offset into stripe times texture height
        S_TLD    = 12'b0010_0000_0000,  // load texture row division
        S_TDIV   = 12'b0100_0000_0000,  // texture row division
        S_TROW   = 12'b1000_0000_0000   // texture row times width
    } state_t;

    // the last tick steps run in the idle state via the flags below
    logic        toff_reg, toff_next;   // sum and byte scale multiply pending
    logic        emit_reg, emit_next;   // waiting to load the output register

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // configuration registers
    logic [PROJ_W-1:0] proj_dist_reg, proj_dist_next;
    logic [TEXW_W-1:0] tex_width_reg, tex_width_next;
    logic [TEXW_W-1:0] tex_height_reg, tex_height_next;
    logic [BPT_W-1:0]  bpt_reg, bpt_next;

    // column state
    logic [ROW_W-1:0]  current_row_reg, current_row_next;
    logic [ROW_W-1:0]  bottom_row_reg, bottom_row_next;
    logic [H_W-1:0]    stripe_height_reg, stripe_height_next;
    logic [TCOL_W-1:0] texture_column_reg, texture_column_next;
    logic [COL_W-1:0]  active_column_reg, active_column_next;

    // working registers
    logic [IDX_W-1:0]  cos_idx_reg, cos_idx_next;
    logic              cos_zero_reg, cos_zero_next;
    logic [COS_W-1:0]  cos_reg;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [HIT_W-1:0]  hit_reg, hit_next;
    logic [DIST_W+COS_W-1:0] prod_reg, prod_next;

    // shared restoring divider: remainder, dividend/quotient shifter, divisor
    logic [DIST_W-1:0] rem_reg, rem_next;
    logic [H_W-1:0]    dsh_reg, dsh_next;
    logic [DIST_W-1:0] divisor_reg, divisor_next;

    // output register
    logic   pixel_valid_reg, pixel_valid_next;
    pixel_t pixel_reg, pixel_next;

    // cosine quarter wave rom, contents fixed at elaboration
    logic [COS_W-1:0] cos_rom [COS_TABLE_DEPTH];

    for (genvar g = 0; g < COS_TABLE_DEPTH; g++)
    begin : g_cos
        localparam longint unsigned COS_U = (64'(g) << 30) / COS_TABLE_DEPTH;
        assign cos_rom[g] = cos_from_u(COS_U);
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= cos_zero_reg ? '0 : cos_rom[cos_idx_reg];
    end

    // combinational helpers
    logic                 item_accept;
    logic                 out_free;
    logic                 pixel_pending;
    logic [ANGLE_W-1:0]   mag;
    logic [IDX_PROD_W-1:0] idx_prod;
    logic [IDX_PROD_W-1:0] idx_shift;
    logic [NUM_W-1:0]     num;
    logic [DIST_W-1:0]    prep;
    logic                 sat;
    logic [DIST_W:0]      rem_sh;
    logic [DIST_W+1:0]    diff;
    logic                 q_bit;
    logic [DIST_W-1:0]    rem_step;
    logic [H_W-1:0]       dsh_step;
    logic [TCOL_W-1:0]    mod_q;
    logic [TCOL_W-1:0]    mod_rem;
    logic [DIST_W-1:0]    mul_a;
    logic [COS_W-1:0]     mul_b;
    logic                 mul_en;
    logic signed [17:0]   dft_s;
    logic [H_W-1:0]       dft;
    logic [16:0]          ceil_h;
    logic signed [17:0]   top_s;
    logic [17:0]          bot_u;
    logic [TEXEL_W-1:0]   offs_sum;

    assign item_stall  = (state_reg != S_IDLE) || toff_reg || emit_reg;
    assign item_accept = item_valid && !item_stall;
    assign out_free    = !pixel_valid_reg || !pixel_stall;
    assign pixel_pending = (current_row_reg < bottom_row_reg) && (stripe_height_reg != '0);

    // angle magnitude; at or past a right angle the cosine is zero
    assign mag       = item.angle_offset[ANGLE_W-1] ? (12'd0 - item.angle_offset)
                                                    : item.angle_offset;
    assign idx_prod  = IDX_PROD_W'(mag[9:0]) * IDX_PROD_W'(COS_TABLE_DEPTH);
    assign idx_shift = idx_prod >> 10;

    assign num  = NUM_W'(proj_dist_reg) * NUM_W'(NUM_CONST);
    assign prep = prod_reg[DIST_W+COS_W-1:COS_W];
    // quotient above 16 bits, or a zero divisor, saturates the height
    assign sat  = 40'(num) >= {prep, 16'd0};

    // one restoring step
    assign rem_sh   = {rem_reg, dsh_reg[H_W-1]};
    assign diff     = {1'b0, rem_sh} - {2'b0, divisor_reg};
    assign q_bit    = !diff[DIST_W+1];
    assign rem_step = q_bit ? diff[DIST_W-1:0] : rem_sh[DIST_W-1:0];
    assign dsh_step = {dsh_reg[H_W-2:0], q_bit};

    // remainder below the tile size, so only the low bits of hit - q * tile matter
    assign mod_q   = TCOL_W'(prod_reg >> MOD_SHIFT);
    assign mod_rem = hit_reg[TCOL_W-1:0] - TCOL_W'(mod_q * TCOL_W'(TILE_SIZE));

    // distance from the unclamped stripe top, clamped at zero
    assign dft_s = $signed({6'd0, current_row_reg}) + $signed({3'd0, stripe_height_reg[H_W-1:1]})
                   - $signed(18'(HALF_HEIGHT));
    assign dft   = dft_s[17] ? '0 : dft_s[H_W-1:0];

    // row clamp
    assign ceil_h = (17'(stripe_height_reg) + 17'd1) >> 1;
    assign top_s  = $signed(18'(HALF_HEIGHT)) - $signed({1'b0, ceil_h});
    assign bot_u  = 18'(HALF_HEIGHT) + 18'(stripe_height_reg[H_W-1:1]);

    assign offs_sum = prod_reg[TEXEL_W-1:0] + TEXEL_W'(texture_column_reg);

    // shared multiplier operand select
    always_comb
    begin
        mul_a  = dist_reg;
        mul_b  = cos_reg;
        mul_en = 1'b0;
        if (state_reg == S_MUL)
        begin
            mul_en = 1'b1;
        end
        else if (state_reg == S_MODMUL)
        begin
            mul_a  = MOD_RECIP;
            mul_b  = hit_reg;
            mul_en = 1'b1;
        end
        else if (state_reg == S_TMUL)
        begin
            mul_a  = DIST_W'(dft);
            mul_b  = COS_W'(tex_height_reg);
            mul_en = 1'b1;
        end
        else if (state_reg == S_TROW)
        begin
            mul_a  = DIST_W'(dsh_reg);
            mul_b  = COS_W'(tex_width_reg);
            mul_en = 1'b1;
        end
        else if (toff_reg)
        begin
            mul_a  = DIST_W'(offs_sum);
            mul_b  = COS_W'(bpt_reg);
            mul_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        cnt_next            = cnt_reg;
        toff_next           = 1'b0;
        emit_next           = emit_reg;
        proj_dist_next      = proj_dist_reg;
        tex_width_next      = tex_width_reg;
        tex_height_next     = tex_height_reg;
        bpt_next            = bpt_reg;
        current_row_next    = current_row_reg;
        bottom_row_next     = bottom_row_reg;
        stripe_height_next  = stripe_height_reg;
        texture_column_next = texture_column_reg;
        active_column_next  = active_column_reg;
        cos_idx_next        = cos_idx_reg;
        cos_zero_next       = cos_zero_reg;
        dist_next           = dist_reg;
        hit_next            = hit_reg;
        prod_next           = mul_en ? (mul_a * mul_b) : prod_reg;
        rem_next            = rem_reg;
        dsh_next            = dsh_reg;
        divisor_next        = divisor_reg;
        pixel_valid_next    = pixel_valid_reg && pixel_stall;
        pixel_next          = pixel_reg;

        // register writes must only come while idle; the block itself does not enforce this
        if (cfg_write)
        begin
            case (cfg_index)
                REG_PROJ_DIST:  proj_dist_next  = cfg_data[PROJ_W-1:0];
                REG_TEX_WIDTH:  tex_width_next  = cfg_data[TEXW_W-1:0];
                REG_TEX_HEIGHT: tex_height_next = cfg_data[TEXW_W-1:0];
                REG_BPT:        bpt_next        = cfg_data[BPT_W-1:0];
                default:        ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (toff_reg)
                begin
                    emit_next = 1'b1;
                end
                else if (emit_reg)
                begin
                    if (out_free)
                    begin
                        pixel_valid_next        = 1'b1;
                        pixel_next.screen_x     = active_column_reg;
                        pixel_next.screen_y     = current_row_reg;
                        pixel_next.texel_offset = prod_reg[TEXEL_W-1:0];
                        pixel_next.last_pixel   = (current_row_reg + 12'd1) == bottom_row_reg;
                        current_row_next        = current_row_reg + 12'd1;
                        emit_next               = 1'b0;
                    end
                end
                else if (item_accept)
                begin
                    if (item.kind == KIND_COLUMN)
                    begin
                        cos_zero_next      = mag[ANGLE_W-1:10] != '0;
                        cos_idx_next       = idx_shift[IDX_W-1:0];
                        dist_next          = item.ray_distance;
                        hit_next           = item.hit_vertical ? item.hit_y : item.hit_x;
                        active_column_next = item.column_x;
                        state_next         = S_COS;
                    end
                    else if (pixel_pending)
                    begin
                        state_next = S_TMUL;
                    end
                end
            end
            S_COS:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_SAT;
            end
            S_SAT:
            begin
                cnt_next = CNT_W'(DIV_STEPS - 1);
                if (sat)
                begin
                    stripe_height_next = '1;
                    state_next         = S_MODMUL;
                end
                else
                begin
                    divisor_next = prep;
                    rem_next     = DIST_W'(num >> 16);
                    dsh_next     = num[H_W-1:0];
                    state_next   = S_DIVH;
                end
            end
            S_DIVH:
            begin
                rem_next = rem_step;
                dsh_next = dsh_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    stripe_height_next = dsh_step;
                    state_next         = S_MODMUL;
                end
            end
            S_MODMUL:
            begin
                state_next = S_MODSUB;
            end
            S_MODSUB:
            begin
                texture_column_next = mod_rem;
                state_next          = S_FIN;
            end
            S_FIN:
            begin
                current_row_next = top_s[17] ? '0 : top_s[ROW_W-1:0];
                bottom_row_next  = (bot_u > 18'(SCREEN_HEIGHT)) ? ROW_W'(SCREEN_HEIGHT)
                                                                : bot_u[ROW_W-1:0];
                state_next       = S_IDLE;
            end
            S_TMUL:
            begin
                state_next = S_TLD;
            end
            S_TLD:
            begin
                // high part stays below the height since the row lies inside the stripe
                cnt_next     = CNT_W'(DIV_STEPS - 1);
                divisor_next = DIST_W'(stripe_height_reg);
                rem_next     = DIST_W'(prod_reg[26:16]);
                dsh_next     = prod_reg[H_W-1:0];
                state_next   = S_TDIV;
            end
            S_TDIV:
            begin
                rem_next = rem_step;
                dsh_next = dsh_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_TROW;
                end
            end
            S_TROW:
            begin
                toff_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and column state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            cnt_reg            <= '0;
            toff_reg           <= 1'b0;
            emit_reg           <= 1'b0;
            pixel_valid_reg    <= 1'b0;
            proj_dist_reg      <= PROJ_DIST_RST;
            tex_width_reg      <= TEX_WIDTH_RST;
            tex_height_reg     <= TEX_HEIGHT_RST;
            bpt_reg            <= BPT_RST;
            current_row_reg    <= '0;
            bottom_row_reg     <= '0;
            stripe_height_reg  <= '0;
            texture_column_reg <= '0;
            active_column_reg  <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            cnt_reg            <= cnt_next;
            toff_reg           <= toff_next;
            emit_reg           <= emit_next;
            pixel_valid_reg    <= pixel_valid_next;
            proj_dist_reg      <= proj_dist_next;
            tex_width_reg      <= tex_width_next;
            tex_height_reg     <= tex_height_next;
            bpt_reg            <= bpt_next;
            current_row_reg    <= current_row_next;
            bottom_row_reg     <= bottom_row_next;
            stripe_height_reg  <= stripe_height_next;
            texture_column_reg <= texture_column_next;
            active_column_reg  <= active_column_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        cos_idx_reg  <= cos_idx_next;
        cos_zero_reg <= cos_zero_next;
        dist_reg     <= dist_next;
        hit_reg      <= hit_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        divisor_reg  <= divisor_next;
        pixel_reg    <= pixel_next;
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel       = pixel_reg;

    // a new result word only comes out of the emit step
    a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pixel_valid_reg) |-> $past(emit_reg))
        else $error("result word loaded outside the emit step");

    // each emitted pixel advances the row by one
    a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !toff_reg && emit_reg && out_free)
        |=> current_row_reg == $past(current_row_reg) + 12'd1)
        else $error("row did not advance after a pixel");

    // a tick with nothing left to draw starts no work
    a_empty_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && item.kind == KIND_TICK && !pixel_pending)
        |=> (state_reg == S_IDLE && !toff_reg && !emit_reg))
        else $error("empty tick started the pixel sequence");

    // the divider remainder stays below the divisor on every step
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVH || state_reg == S_TDIV)
        |-> rem_reg < divisor_reg)
        else $error("divider remainder out of range");

endmodule

`default_nettype wire
